### hdl/kmpq_pkg.sv
package kmpq_pkg;

	// table geometry
	localparam int CAPACITY  = 16;
	localparam int COST_BITS = 16;
	localparam int KEY_BITS  = 16;
	localparam int IDX_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_BITS  = $clog2(CAPACITY + 1);

	typedef logic [KEY_BITS-1:0]  key_t;
	typedef logic [COST_BITS-1:0] cost_t;
	typedef logic [IDX_BITS-1:0]  idx_t;
	typedef logic [CNT_BITS-1:0]  cnt_t;

	// operation codes
	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	// result status codes
	typedef enum logic [2:0] {
		ST_UPDATED  = 3'd0,
		ST_INSERTED = 3'd1,
		ST_FULL     = 3'd2,
		ST_REMOVED  = 3'd3,
		ST_EMPTY    = 3'd4
	} status_t;

	// controller states
	typedef enum logic [1:0] {
		CS_IDLE,
		CS_SWEEP,
		CS_FINISH
	} ctrl_state_t;

	// what the commit does to the selected cell
	typedef enum logic [1:0] {
		CK_COST,
		CK_INSERT,
		CK_REMOVE
	} commit_kind_t;

	// search wave that walks the cell chain, one cell per cycle
	typedef struct packed {
		logic  active;
		logic  op;
		key_t  key;
		cost_t cost;
		logic  match;
		idx_t  match_idx;
		logic  have_free;
		idx_t  free_idx;
		logic  found;
		cost_t best_cost;
		idx_t  min_idx;
		key_t  min_key;
	} sweep_t;

	// table write broadcast to all cells
	typedef struct packed {
		logic         en;
		commit_kind_t kind;
		idx_t         idx;
		key_t         key;
		cost_t        cost;
	} commit_t;

	// fit an input cost to the stored cost width
	function automatic cost_t to_cost(input logic [15:0] c);
		logic [31:0] w;
		w = {16'b0, c};
		return w[COST_BITS-1:0];
	endfunction

endpackage

### hdl/kmpq_cell.sv
module kmpq_cell
	import kmpq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  idx_t    cell_idx,
	input  sweep_t  sweep_in,
	output sweep_t  sweep_out,
	input  commit_t commit
);

	logic   valid_q;
	key_t   key_q;
	cost_t  cost_q;
	logic   active_s1;
	sweep_t sweep_s1;
	sweep_t sweep_nxt;
	logic   sel;

	assign sel = commit.en && (commit.idx == cell_idx);

	// fold this slot into the running search
	always_comb begin
		sweep_nxt = sweep_in;
		if (valid_q && (key_q == sweep_in.key) && !sweep_in.match) begin
			sweep_nxt.match     = 1'b1;
			sweep_nxt.match_idx = cell_idx;
		end
		if (!valid_q && !sweep_in.have_free) begin
			sweep_nxt.have_free = 1'b1;
			sweep_nxt.free_idx  = cell_idx;
		end
		// strict compare keeps ties on the lower slot
		if (valid_q && (!sweep_in.found || (cost_q < sweep_in.best_cost))) begin
			sweep_nxt.found     = 1'b1;
			sweep_nxt.best_cost = cost_q;
			sweep_nxt.min_idx   = cell_idx;
			sweep_nxt.min_key   = key_q;
		end
	end

	// wave marker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_s1 <= 1'b0;
		end else begin
			active_s1 <= sweep_in.active;
		end
	end

	// wave payload
	always_ff @(posedge clk) begin
		sweep_s1 <= sweep_nxt;
	end

	always_comb begin
		sweep_out        = sweep_s1;
		sweep_out.active = active_s1;
	end

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (sel) begin
			valid_q <= (commit.kind != CK_REMOVE);
		end
	end

	// slot contents
	always_ff @(posedge clk) begin
		if (sel) begin
			case (commit.kind)
				CK_COST: begin
					cost_q <= commit.cost;
				end
				CK_INSERT: begin
					key_q  <= commit.key;
					cost_q <= commit.cost;
				end
				CK_REMOVE: begin
					cost_q <= '0;
				end
				default: begin
					cost_q <= cost_q;
				end
			endcase
		end
	end

endmodule

### hdl/kmpq_ctrl.sv
module kmpq_ctrl
	import kmpq_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          op,
	input  logic [15:0]   item_key,
	input  logic [15:0]   cost,
	output sweep_t        launch,
	input  sweep_t        tail,
	output commit_t       commit,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [2:0]    status,
	output logic [15:0]   removed_key
);

	ctrl_state_t state_q, state_nxt;
	logic        launch_act_q;
	sweep_t      launch_q;
	sweep_t      tail_q;
	cnt_t        count_q;
	logic        out_valid_q;
	status_t     status_q;
	key_t        rkey_q;
	logic        out_free;
	logic        in_acc;
	logic        finish;
	status_t     res_status;
	key_t        res_key;

	assign out_free = !out_valid_q || !out_stall;
	assign finish   = (state_q == CS_FINISH) && out_free;
	assign in_acc   = in_valid && !in_stall;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			CS_IDLE: begin
				if (in_valid) state_nxt = CS_SWEEP;
			end
			CS_SWEEP: begin
				if (tail.active) state_nxt = CS_FINISH;
			end
			CS_FINISH: begin
				if (out_free) state_nxt = in_valid ? CS_SWEEP : CS_IDLE;
			end
			default: begin
				state_nxt = CS_IDLE;
			end
		endcase
	end

	// state outputs: a new beat may enter as the previous one commits
	always_comb begin
		case (state_q)
			CS_IDLE:   in_stall = 1'b0;
			CS_SWEEP:  in_stall = 1'b1;
			CS_FINISH: in_stall = !out_free;
			default:   in_stall = 1'b1;
		endcase
	end

	// decide the result and the table write from the finished wave
	always_comb begin
		res_status  = ST_EMPTY;
		res_key     = '0;
		commit.en   = 1'b0;
		commit.kind = CK_COST;
		commit.idx  = tail_q.match_idx;
		commit.key  = tail_q.key;
		commit.cost = tail_q.cost;
		if (tail_q.op == OP_UPDATE) begin
			if (tail_q.match) begin
				res_status = ST_UPDATED;
				commit.en  = finish;
			end else if (tail_q.have_free) begin
				res_status  = ST_INSERTED;
				commit.en   = finish;
				commit.kind = CK_INSERT;
				commit.idx  = tail_q.free_idx;
			end else begin
				res_status = ST_FULL;
			end
		end else if (tail_q.found && (count_q != '0)) begin
			res_status  = ST_REMOVED;
			res_key     = tail_q.min_key;
			commit.en   = finish;
			commit.kind = CK_REMOVE;
			commit.idx  = tail_q.min_idx;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= CS_IDLE;
			launch_act_q <= 1'b0;
			count_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_nxt;
			launch_act_q <= in_acc;
			if (finish) begin
				out_valid_q <= 1'b1;
				if (commit.en && (commit.kind == CK_INSERT)) begin
					count_q <= count_q + cnt_t'(1);
				end else if (commit.en && (commit.kind == CK_REMOVE)) begin
					count_q <= count_q - cnt_t'(1);
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// launch beat with cleared search flags
	always_ff @(posedge clk) begin
		if (in_acc) begin
			launch_q.active    <= 1'b0;
			launch_q.op        <= op;
			launch_q.key       <= item_key;
			launch_q.cost      <= to_cost(cost);
			launch_q.match     <= 1'b0;
			launch_q.match_idx <= '0;
			launch_q.have_free <= 1'b0;
			launch_q.free_idx  <= '0;
			launch_q.found     <= 1'b0;
			launch_q.best_cost <= '0;
			launch_q.min_idx   <= '0;
			launch_q.min_key   <= '0;
		end
	end

	// capture the wave leaving the last cell
	always_ff @(posedge clk) begin
		if (tail.active && (state_q == CS_SWEEP)) begin
			tail_q <= tail;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (finish) begin
			status_q <= res_status;
			rkey_q   <= res_key;
		end
	end

	always_comb begin
		launch        = launch_q;
		launch.active = launch_act_q;
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign removed_key = rkey_q;

endmodule

### hdl/keyed_min_priority_queue_unit.sv
// Keyed min priority queue: a chain of CAPACITY slot cells searched by one wave.
// The wave visits one cell per cycle; the controller then captures it at the end of the
// chain and commits the table write as the result is loaded.
// The block takes no new item while a search is in flight; the next item may enter on the
// cycle the previous result is loaded, so the chain length sets the rate.
// Reset clears valid bits, entry count and control; keys and costs are not cleared.
module keyed_min_priority_queue_unit
	import kmpq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [15:0] item_key,
	input  logic [15:0] cost,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [15:0] removed_key
);

	sweep_t               chain [CAPACITY+1];
	commit_t              commit;
	logic [CAPACITY-1:0]  wave_act;

	kmpq_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.item_key    (item_key),
		.cost        (cost),
		.launch      (chain[0]),
		.tail        (chain[CAPACITY]),
		.commit      (commit),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.removed_key (removed_key)
	);

	// slot cells, wave flows from slot 0 upward
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		kmpq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cell_idx  (idx_t'(i)),
			.sweep_in  (chain[i]),
			.sweep_out (chain[i+1]),
			.commit    (commit)
		);
		assign wave_act[i] = chain[i+1].active;
	end

	// only one wave in the chain at a time
	a_one_wave: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(wave_act))
		else $error("more than one search wave in the cell chain");

	// input is held off after an accepted beat
	a_hold_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("beat accepted while search in flight");

	// wave reaching the end of the chain means the input is held off
	a_tail_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		chain[CAPACITY].active |-> in_stall)
		else $error("wave finished while input open");

	// a table write only happens together with a result load
	a_commit_result: assert property (@(posedge clk) disable iff (!arst_n)
		commit.en |=> out_valid)
		else $error("table write without result beat");

endmodule

### verif/keyed_min_priority_queue_unit_test.sv
`timescale 1ns / 1ps

module keyed_min_priority_queue_unit_test;
	import kmpq_pkg::*;

	localparam int N_RANDOM   = 1425;
	localparam int MAX_IDLE   = 14;
	localparam int LONG_HOLD  = 300;
	localparam int PHASE_LEN  = 40;

	// one directed row; reps > 1 inserts consecutive keys with the same cost
	typedef struct {
		logic        op;
		key_t        key;
		logic [15:0] cost;
		int          reps;
		logic        typed;
		status_t     st;
		key_t        rk;
	} dir_row_t;

	typedef struct {
		status_t st;
		key_t    rk;
	} queue_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        op = OP_UPDATE;
	logic [15:0] item_key = '0;
	logic [15:0] cost = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic [15:0] removed_key;

	// shadow copy of the slot table
	logic  shadow_valid [CAPACITY];
	key_t  shadow_key   [CAPACITY];
	cost_t shadow_cost  [CAPACITY];

	queue_result_t pending_results[$];
	queue_result_t head_result;

	int   mismatches = 0;
	int   items_sent = 0;
	int   status_seen [5];
	logic send_idle = 1'b1;
	logic recv_idle = 1'b1;

	// directed rows: empty remove, key and cost extremes, fill to full, ties
	localparam int N_DIR = 11;
	dir_row_t dir_rows [N_DIR] = '{
		'{OP_REMOVE, 16'h5A5A, 16'hBEEF, 1,  1'b1, ST_EMPTY,    16'h0000},
		'{OP_UPDATE, 16'h0000, 16'hFFFF, 1,  1'b1, ST_INSERTED, 16'h0000},
		'{OP_UPDATE, 16'hFFFF, 16'h0000, 1,  1'b1, ST_INSERTED, 16'h0000},
		'{OP_UPDATE, 16'h0000, 16'h0005, 1,  1'b1, ST_UPDATED,  16'h0000},
		'{OP_REMOVE, 16'h0000, 16'hFFFF, 1,  1'b1, ST_REMOVED,  16'hFFFF},
		'{OP_UPDATE, 16'h0100, 16'h0007, 15, 1'b0, ST_UPDATED,  16'h0000},
		'{OP_UPDATE, 16'h0200, 16'h0001, 1,  1'b1, ST_FULL,     16'h0000},
		'{OP_UPDATE, 16'h0105, 16'h0003, 1,  1'b1, ST_UPDATED,  16'h0000},
		'{OP_REMOVE, 16'hFFFF, 16'h1234, 1,  1'b1, ST_REMOVED,  16'h0105},
		// key zero comes back as a real removal
		'{OP_REMOVE, 16'hA5A5, 16'h0000, 1,  1'b1, ST_REMOVED,  16'h0000},
		// equal costs left: lowest slot wins
		'{OP_REMOVE, 16'h0000, 16'h0000, 1,  1'b0, ST_REMOVED,  16'h0000}
	};

	keyed_min_priority_queue_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.item_key    (item_key),
		.cost        (cost),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.removed_key (removed_key)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("timeout with %0d results outstanding", pending_results.size());
		$display("** keyed_min_priority_queue_unit: FAILED **");
		$finish;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: %s mismatch, got %0h want %0h", $time, what, got, want);
		mismatches++;
	endtask

	// apply one item to the shadow table and return the result it produces
	function automatic void apply_to_shadow(input logic o, input key_t k,
			input logic [15:0] c, output status_t st, output key_t rk);
		int hit;
		int free_slot;
		int best;
		hit = -1;
		free_slot = -1;
		best = -1;
		st = ST_EMPTY;
		rk = '0;
		if (o == OP_UPDATE) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (shadow_valid[i] && shadow_key[i] == k && hit < 0) hit = i;
				if (!shadow_valid[i] && free_slot < 0) free_slot = i;
			end
			if (hit >= 0) begin
				shadow_cost[hit] = cost_t'(c);
				st = ST_UPDATED;
			end else if (free_slot >= 0) begin
				shadow_valid[free_slot] = 1'b1;
				shadow_key[free_slot] = k;
				shadow_cost[free_slot] = cost_t'(c);
				st = ST_INSERTED;
			end else begin
				st = ST_FULL;
			end
		end else begin
			// strict less-than keeps the lowest slot on ties
			for (int i = 0; i < CAPACITY; i++) begin
				if (shadow_valid[i] && (best < 0 || shadow_cost[i] < shadow_cost[best])) best = i;
			end
			if (best >= 0) begin
				rk = shadow_key[best];
				shadow_valid[best] = 1'b0;
				shadow_cost[best] = '0;
				st = ST_REMOVED;
			end
		end
	endfunction

	// offer one input beat, after a random gap when send_idle is set; predict once it is taken
	task automatic send_item(input logic o, input key_t k, input logic [15:0] c,
			input logic typed, input status_t typed_st, input key_t typed_rk);
		int gap;
		status_t pst;
		key_t prk;
		gap = send_idle ? $urandom_range(0, MAX_IDLE) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		item_key <= k;
		cost <= c;
		do @(posedge clk); while (in_stall);
		apply_to_shadow(o, k, c, pst, prk);
		if (typed) begin
			pending_results.push_back('{st: typed_st, rk: typed_rk});
		end else begin
			pending_results.push_back('{st: pst, rk: prk});
		end
		items_sent++;
	endtask

	// stimulus: reset, directed rows, then random phases
	initial begin
		logic        r_op;
		key_t        r_key;
		logic [15:0] r_cost;
		int          remove_pct;
		foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
		foreach (status_seen[i]) status_seen[i] = 0;
		remove_pct = 50;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[r]) begin
			for (int n = 0; n < dir_rows[r].reps; n++) begin
				send_item(dir_rows[r].op, dir_rows[r].key + key_t'(n), dir_rows[r].cost,
					dir_rows[r].typed, dir_rows[r].st, dir_rows[r].rk);
			end
		end

		for (int n = 0; n < N_RANDOM; n++) begin
			// each phase leans toward filling, churning or draining the table
			if (n % PHASE_LEN == 0) begin
				case ($urandom_range(0, 3))
					0: begin
						remove_pct = 15;
					end
					1: begin
						remove_pct = 45;
					end
					2: begin
						remove_pct = 55;
					end
					default: begin
						remove_pct = 85;
					end
				endcase
				send_idle = ($urandom_range(0, 3) != 0);
			end
			r_op = ($urandom_range(0, 99) < remove_pct) ? OP_REMOVE : OP_UPDATE;
			// small key pool so updates hit stored keys, plus full range and extremes
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					r_key = key_t'($urandom_range(0, 23));
				end
				6, 7, 8: begin
					r_key = key_t'($urandom());
				end
				default: begin
					r_key = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
				end
			endcase
			// narrow costs force ties
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					r_cost = 16'($urandom_range(0, 7));
				end
				4, 5, 6, 7: begin
					r_cost = 16'($urandom());
				end
				8: begin
					r_cost = 16'h0000;
				end
				default: begin
					r_cost = 16'hFFFF;
				end
			endcase
			send_item(r_op, r_key, r_cost, 1'b0, ST_UPDATED, '0);
		end
		in_valid <= 1'b0;

		// drain, then give the block time to show any stray beat
		while (pending_results.size() != 0) @(posedge clk);
		repeat (CAPACITY + 4) @(posedge clk);

		$display("ran %0d items: %0d inserts, %0d cost updates, %0d inserts dropped on full,",
			items_sent, status_seen[ST_INSERTED], status_seen[ST_UPDATED], status_seen[ST_FULL]);
		$display("%0d removes, %0d removes on empty, %0d mismatches",
			status_seen[ST_REMOVED], status_seen[ST_EMPTY], mismatches);
		if (mismatches == 0) begin
			$display("** keyed_min_priority_queue_unit: PASSED **");
		end else begin
			$display("** keyed_min_priority_queue_unit: FAILED **");
		end
		$finish;
	end

	// result side: random stall before each beat, two long hold-offs to back up the input
	initial begin
		int n;
		int beat_idx;
		beat_idx = 0;
		forever begin
			if (beat_idx % PHASE_LEN == 0) recv_idle = ($urandom_range(0, 3) != 0);
			if (beat_idx == 60 || beat_idx == 700) begin
				n = LONG_HOLD;
			end else begin
				n = recv_idle ? $urandom_range(0, MAX_IDLE) : 0;
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			beat_idx++;
		end
	end

	// compare every accepted result beat with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (status <= ST_EMPTY) status_seen[status]++;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result beat, status", status, 0);
			end else begin
				head_result = pending_results.pop_front();
				if (status !== head_result.st) begin
					report_mismatch("status", status, head_result.st);
				end
				if (removed_key !== head_result.rk) begin
					report_mismatch("removed_key", removed_key, head_result.rk);
				end
			end
		end
	end

endmodule
